### sv/pop3clp_pkg.sv
`timescale 1ns / 1ps

package pop3clp_pkg;

  // Parameter text counts saturate at this length.
  localparam int unsigned PARAM_MAX = 1024;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned NUM_VERBS = 14;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic        param_valid;
    logic [7:0]  param_byte;
    count_t      param_position;
    logic        line_done;
    logic [31:0] command_word;
    logic [3:0]  command_id;
    count_t      param_length;
  } result_t;

  typedef logic [31:0] verb_table_t [NUM_VERBS];

  localparam verb_table_t VERBS = '{
    {8'h41, 8'h50, 8'h4F, 8'h50},  // APOP
    {8'h43, 8'h41, 8'h50, 8'h41},  // CAPA
    {8'h44, 8'h45, 8'h4C, 8'h45},  // DELE
    {8'h4C, 8'h49, 8'h53, 8'h54},  // LIST
    {8'h4E, 8'h4F, 8'h4F, 8'h50},  // NOOP
    {8'h50, 8'h41, 8'h53, 8'h53},  // PASS
    {8'h51, 8'h55, 8'h49, 8'h54},  // QUIT
    {8'h52, 8'h45, 8'h54, 8'h52},  // RETR
    {8'h52, 8'h53, 8'h45, 8'h54},  // RSET
    {8'h53, 8'h54, 8'h41, 8'h54},  // STAT
    {8'h53, 8'h54, 8'h4C, 8'h53},  // STLS
    {8'h54, 8'h4F, 8'h50, 8'h00},  // TOP
    {8'h55, 8'h53, 8'h45, 8'h52},  // USER
    {8'h55, 8'h49, 8'h44, 8'h4C}   // UIDL
  };

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    if ((b >= CHAR_LOW_A) && (b <= CHAR_LOW_Z)) begin
      return b - CASE_DIFF;
    end
    return b;
  endfunction

  // A zero word never matches, since no verb packs to zero.
  function automatic logic [3:0] verb_id(input logic [31:0] word);
    logic [3:0] id;
    id = '0;
    for (int i = 0; i < NUM_VERBS; i++) begin
      if (VERBS[i] == word) begin
        id = 4'(i + 1);
      end
    end
    return id;
  endfunction

endpackage

### sv/pop3clp_in_if.sv
`timescale 1ns / 1ps

interface pop3clp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

### sv/pop3clp_out_if.sv
`timescale 1ns / 1ps

interface pop3clp_out_if;
  logic        valid;
  logic        ready;
  logic        param_valid;
  logic [7:0]  param_byte;
  logic [10:0] param_position;
  logic        line_done;
  logic [31:0] command_word;
  logic [3:0]  command_id;
  logic [10:0] param_length;

  modport source (
    output valid, output param_valid, output param_byte, output param_position,
    output line_done, output command_word, output command_id, output param_length,
    input ready
  );
  modport sink (
    input valid, input param_valid, input param_byte, input param_position,
    input line_done, input command_word, input command_id, input param_length,
    output ready
  );
endinterface

### sv/pop3clp_core.sv
`timescale 1ns / 1ps

module pop3clp_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  output pop3clp_pkg::result_t result
);
  import pop3clp_pkg::*;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_CMD,
    PH_CSP,
    PH_PARM
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] packed_command, packed_command_next;
  logic [2:0]  command_count, command_count_next;
  count_t      param_count, param_count_next;
  count_t      trimmed_count, trimmed_count_next;

  logic        ws;
  logic        used;
  logic [7:0]  upper;
  logic [31:0] word;
  phase_t      ph;

  assign ws    = is_space(data_byte);
  assign upper = to_upper(data_byte);

  // The phases fall through within one byte: a byte that ends one phase is
  // handled by the next.
  always_comb begin
    ph                  = phase;
    used                = 1'b0;
    word                = '0;
    packed_command_next = packed_command;
    command_count_next  = command_count;
    param_count_next    = param_count;
    trimmed_count_next  = trimmed_count;
    result              = '0;

    if (ph == PH_LEAD) begin
      if (ws) begin
        used = 1'b1;
      end else begin
        ph = PH_CMD;
      end
    end

    if (!used && ph == PH_CMD) begin
      if (!ws) begin
        case (command_count)
          3'd0: packed_command_next[31:24] = upper;
          3'd1: packed_command_next[23:16] = upper;
          3'd2: packed_command_next[15:8]  = upper;
          3'd3: packed_command_next[7:0]   = upper;
          default: ;
        endcase
        if (command_count < 3'd5) begin
          command_count_next = command_count + 3'd1;
        end
        used = 1'b1;
      end else begin
        ph = PH_CSP;
      end
    end

    if (!used && ph == PH_CSP) begin
      if (ws && data_byte != CHAR_LF) begin
        used = 1'b1;
      end else begin
        ph = PH_PARM;
      end
    end

    if (!used && ph == PH_PARM) begin
      if (data_byte == CHAR_LF) begin
        word                  = (command_count >= 3'd5) ? '0 : packed_command;
        result.line_done      = 1'b1;
        result.command_word   = word;
        result.command_id     = verb_id(word);
        result.param_length   = trimmed_count;
        ph                    = PH_CMD;
        packed_command_next   = '0;
        command_count_next    = '0;
        param_count_next      = '0;
        trimmed_count_next    = '0;
      end else begin
        result.param_valid    = 1'b1;
        result.param_byte     = data_byte;
        result.param_position = param_count;
        if (param_count < count_t'(PARAM_MAX)) begin
          param_count_next = param_count + count_t'(1);
        end
        if (!ws) begin
          trimmed_count_next = param_count_next;
        end
      end
    end

    phase_next = ph;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEAD;
      packed_command <= '0;
      command_count  <= '0;
      param_count    <= '0;
      trimmed_count  <= '0;
    end else if (step) begin
      phase          <= phase_next;
      packed_command <= packed_command_next;
      command_count  <= command_count_next;
      param_count    <= param_count_next;
      trimmed_count  <= trimmed_count_next;
    end
  end

endmodule

### sv/pop3_command_line_parser.sv
`timescale 1ns / 1ps

// POP3 client command parser. Each byte transfer on stream_in yields exactly
// one result transfer on result_out, in order. A byte is held in an input
// register, the parse state and the result are worked out from it
// combinationally, and the result lands in an output register; the block
// takes one byte per clock unless result_out stalls. Since the input and
// output registers are separate, a new byte is taken while an earlier result
// still waits for its transfer. Leading whitespace is skipped before the first
// command after reset, up to four command characters are packed upper-cased
// into command_word (zero for longer words), parameter bytes pass through with
// their position, and lengths saturate at 1024. A newline after the command
// reports command_word, command_id and the right-trimmed parameter length.
module pop3_command_line_parser (
  input  logic  clk,
  input  logic  rst,
  pop3clp_in_if.sink    stream_in,
  pop3clp_out_if.source result_out
);
  import pop3clp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  result_t    out_result;
  result_t    step_result;
  logic       advance;

  assign advance         = in_valid && (!out_valid || result_out.ready);
  assign stream_in.ready = !in_valid || advance;

  pop3clp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (stream_in.ready) begin
        in_valid <= stream_in.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream_in.valid && stream_in.ready) begin
      in_byte <= stream_in.data_byte;
    end
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.param_valid    = out_result.param_valid;
  assign result_out.param_byte     = out_result.param_byte;
  assign result_out.param_position = out_result.param_position;
  assign result_out.line_done      = out_result.line_done;
  assign result_out.command_word   = out_result.command_word;
  assign result_out.command_id     = out_result.command_id;
  assign result_out.param_length   = out_result.param_length;

endmodule
